/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

/* rtl/brf_pkg.sv */
// ---------------------------------------------------------------------------
// brf_pkg
// Shared constants, codes and types of the byte ring FIFO.
// ---------------------------------------------------------------------------
`default_nettype none
package brf_pkg;

  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int STEP_W     = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int WIDE_W     = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;

  localparam int CAP_MIN_INT   = 32;
  localparam int CAP_RESET_INT = (DEPTH < 1024) ? DEPTH : 1024;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_RESET_INT);

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ACT_PUT    = 3'd0,
    ACT_GET    = 3'd1,
    ACT_SKIP   = 3'd2,
    ACT_COMMIT = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_STATUS = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERWRITE = 3'd3,
    ST_STEP      = 3'd4
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

/* rtl/brf_channels.sv */
// ---------------------------------------------------------------------------
// brf channels
// Valid/ready channel interfaces for actions, results and configuration.
// ---------------------------------------------------------------------------
`default_nettype none
interface brf_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic [7:0]                data_byte;
  logic [brf_pkg::STEP_W-1:0] step_count;
  modport source (output valid, action, data_byte, step_count, input ready);
  modport sink   (input valid, action, data_byte, step_count, output ready);
endinterface

interface brf_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 read_byte;
  logic [2:0]                 status;
  logic [brf_pkg::CNT_W-1:0]  fill_level;
  logic [brf_pkg::CNT_W-1:0]  free_space;
  logic [brf_pkg::CNT_W-1:0]  contiguous_run;
  logic [brf_pkg::ADDR_W-1:0] read_position;
  logic [brf_pkg::ADDR_W-1:0] write_position;
  modport source (output valid, read_byte, status, fill_level, free_space,
                  contiguous_run, read_position, write_position, input ready);
  modport sink   (input valid, read_byte, status, fill_level, free_space,
                  contiguous_run, read_position, write_position, output ready);
endinterface

interface brf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [brf_pkg::CFG_IDX_W-1:0]  index;
  logic [brf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/brf_ram.sv */
// ---------------------------------------------------------------------------
// brf_ram
// Byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module brf_ram (
  input  wire logic              clk,
  input  wire brf_pkg::mem_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0] mem [brf_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/brf_ctrl.sv */
// ---------------------------------------------------------------------------
// brf_ctrl
// Index and fill tracking, action decode, store sweep and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module brf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  brf_in_if.sink                 items,
  brf_out_if.source              results,
  brf_cfg_if.sink                cfg,
  output brf_pkg::mem_req_t      mem_req,
  input  wire logic [7:0]        mem_rdata
);

  localparam int AW = brf_pkg::ADDR_W;
  localparam int CW = brf_pkg::CNT_W;
  localparam int WW = brf_pkg::WIDE_W;

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_LOAD  = 3'b100
  } state_t;

  function automatic logic [WW-1:0] wrap_add(input logic [WW-1:0] a,
                                             input logic [WW-1:0] b,
                                             input logic [WW-1:0] cap);
    logic [WW-1:0] s;
    s = a + b;
    if (s >= cap) begin
      s = s - cap;
    end
    return s;
  endfunction

  state_t            state;
  logic [AW-1:0]     sweep_addr;
  logic [CW-1:0]     capacity;
  logic              overwrite;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     wr_idx;
  logic [CW-1:0]     used;

  logic              pend_get;
  brf_pkg::status_t  pend_status;
  logic [CW-1:0]     pend_fill;
  logic [CW-1:0]     pend_free;
  logic [CW-1:0]     pend_run;
  logic [AW-1:0]     pend_rd;
  logic [AW-1:0]     pend_wr;

  logic              out_valid;

  logic              in_fire;
  logic              cfg_fire;
  logic [AW-1:0]     rd_idx_next;
  logic [AW-1:0]     wr_idx_next;
  logic [CW-1:0]     used_next;
  brf_pkg::status_t  status_next;
  logic              put_we;
  logic              get_re;
  logic [CW-1:0]     run_next;
  logic [WW-1:0]     cap_w;
  logic [WW-1:0]     used_w;
  logic [WW-1:0]     step_w;
  logic [WW-1:0]     cfg_w;
  logic [CW-1:0]     cap_clamped;

  assign in_fire  = items.valid && items.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign items.ready = (state == S_IDLE) && !rst;
  assign cfg.ready   = !rst;

  assign cap_w  = WW'(capacity);
  assign used_w = WW'(used);
  assign step_w = WW'(items.step_count);
  assign cfg_w  = WW'(cfg.data);

  always_comb begin
    if (cfg_w < WW'(brf_pkg::CAP_MIN_INT)) begin
      cap_clamped = CW'(brf_pkg::CAP_MIN_INT);
    end else if (cfg_w > WW'(brf_pkg::DEPTH)) begin
      cap_clamped = CW'(brf_pkg::DEPTH);
    end else begin
      cap_clamped = cfg_w[CW-1:0];
    end
  end

  always_comb begin
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    used_next   = used;
    status_next = brf_pkg::ST_OK;
    put_we      = 1'b0;
    get_re      = 1'b0;
    unique case (items.action)
      brf_pkg::ACT_PUT: begin
        if (used >= capacity) begin
          if (overwrite) begin
            rd_idx_next = AW'(wrap_add(WW'(rd_idx), WW'(1), cap_w));
            wr_idx_next = AW'(wrap_add(WW'(wr_idx), WW'(1), cap_w));
            put_we      = 1'b1;
            status_next = brf_pkg::ST_OVERWRITE;
          end else begin
            status_next = brf_pkg::ST_FULL;
          end
        end else begin
          wr_idx_next = AW'(wrap_add(WW'(wr_idx), WW'(1), cap_w));
          used_next   = used + CW'(1);
          put_we      = 1'b1;
        end
      end
      brf_pkg::ACT_GET: begin
        if (used == '0) begin
          status_next = brf_pkg::ST_EMPTY;
        end else begin
          get_re = 1'b1;
          if (used == CW'(1)) begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            used_next   = '0;
          end else begin
            rd_idx_next = AW'(wrap_add(WW'(rd_idx), WW'(1), cap_w));
            used_next   = used - CW'(1);
          end
        end
      end
      brf_pkg::ACT_SKIP: begin
        if (!overwrite) begin
          if (step_w >= used_w) begin
            rd_idx_next = '0;
            wr_idx_next = '0;
            used_next   = '0;
          end else begin
            used_next   = CW'(used_w - step_w);
            rd_idx_next = AW'(wrap_add(WW'(rd_idx), step_w, cap_w));
          end
        end
      end
      brf_pkg::ACT_COMMIT: begin
        if (!overwrite) begin
          if (step_w > cap_w - used_w) begin
            status_next = brf_pkg::ST_STEP;
          end else begin
            used_next   = CW'(used_w + step_w);
            wr_idx_next = AW'(wrap_add(WW'(wr_idx), step_w, cap_w));
          end
        end
      end
      brf_pkg::ACT_CLEAR: begin
        rd_idx_next = '0;
        wr_idx_next = '0;
        used_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (used_next == '0) begin
      run_next = '0;
    end else if (rd_idx_next < wr_idx_next) begin
      run_next = used_next;
    end else begin
      run_next = capacity - CW'(rd_idx_next);
    end
  end

  always_comb begin
    mem_req = '0;
    if (state == S_SWEEP) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = sweep_addr;
      mem_req.wdata = '0;
    end else begin
      mem_req.we    = in_fire && put_we;
      mem_req.waddr = wr_idx;
      mem_req.wdata = items.data_byte;
      mem_req.re    = in_fire && get_re;
      mem_req.raddr = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      capacity   <= brf_pkg::CAP_RESET;
      overwrite  <= 1'b0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      used       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_LOAD && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(brf_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!out_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_SWEEP;
        end
      endcase
      if (cfg_fire && cfg.index == brf_pkg::REG_CAPACITY) begin
        capacity <= cap_clamped;
        rd_idx   <= '0;
        wr_idx   <= '0;
        used     <= '0;
      end else if (in_fire) begin
        rd_idx <= rd_idx_next;
        wr_idx <= wr_idx_next;
        used   <= used_next;
      end
      if (cfg_fire && cfg.index == brf_pkg::REG_OVERWRITE) begin
        overwrite <= cfg.data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_get    <= get_re;
      pend_status <= status_next;
      pend_fill   <= used_next;
      pend_free   <= capacity - used_next;
      pend_run    <= run_next;
      pend_rd     <= rd_idx_next;
      pend_wr     <= wr_idx_next;
    end
    if (state == S_LOAD && (!out_valid || results.ready)) begin
      results.read_byte      <= pend_get ? mem_rdata : 8'd0;
      results.status         <= pend_status;
      results.fill_level     <= pend_fill;
      results.free_space     <= pend_free;
      results.contiguous_run <= pend_run;
      results.read_position  <= pend_rd;
      results.write_position <= pend_wr;
    end
  end

  assign results.valid = out_valid;

  `ASSERT_HOLDS(a_fill_in_cap, clk, rst, used <= capacity)
  `ASSERT_HOLDS(a_idx_in_cap, clk, rst, CW'(rd_idx) < capacity && CW'(wr_idx) < capacity)
  `ASSERT_IMPLIES(a_empty_home, clk, rst, used == '0, rd_idx == '0 && wr_idx == '0)
  `ASSERT_IMPLIES(a_full_meet, clk, rst, used == capacity, rd_idx == wr_idx)
  `ASSERT_NEXT(a_accept_load, clk, rst, in_fire, state == S_LOAD && !items.ready)

endmodule
`default_nettype wire

/* rtl/byte_ring_fifo_overwrite_core.sv */
// ---------------------------------------------------------------------------
// byte_ring_fifo_overwrite_core
// Circular byte FIFO with optional overwrite of the oldest byte.
// ---------------------------------------------------------------------------
// Results: the pending fields and store read data are registered, then
//   loaded into the result register once it is free; no new action is
//   accepted before that load.
// Reset: indices, fill level and config registers return to defaults; the
//   byte store is then zeroed by a sweep of all DEPTH (1024) addresses,
//   when no action is taken but configuration writes are accepted.
`default_nettype none
module byte_ring_fifo_overwrite_core (
  input  wire logic clk,
  input  wire logic rst,
  brf_in_if.sink    items,
  brf_out_if.source results,
  brf_cfg_if.sink   cfg
);

  brf_pkg::mem_req_t mem_req;
  logic [7:0]        mem_rdata;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  brf_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

/* test/tb_byte_ring_fifo_overwrite_core.sv */
// ---------------------------------------------------------------------------
// tb_byte_ring_fifo_overwrite_core
// Drives put/get/skip/commit/clear/status actions into the byte ring FIFO.
// Every result is checked against its table entry or an in-bench FIFO
// model. A short table covers reset, the extremes and each error code.
// Random phases with varied capacity and overwrite settings follow, with
// random idling on both sides, one long result stall backing up actions.
// ---------------------------------------------------------------------------
module tb_byte_ring_fifo_overwrite_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 130;

  localparam logic [2:0] ACT_ALIAS6 = 3'd6;
  localparam logic [2:0] ACT_ALIAS7 = 3'd7;
  localparam logic [brf_pkg::CFG_IDX_W-1:0] REG_SPARE2 = brf_pkg::CFG_IDX_W'(2);
  localparam logic [brf_pkg::CFG_IDX_W-1:0] REG_SPARE3 = brf_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    logic [7:0]                 read_byte;
    logic [2:0]                 status;
    logic [brf_pkg::CNT_W-1:0]  fill_level;
    logic [brf_pkg::CNT_W-1:0]  free_space;
    logic [brf_pkg::CNT_W-1:0]  contiguous_run;
    logic [brf_pkg::ADDR_W-1:0] read_position;
    logic [brf_pkg::ADDR_W-1:0] write_position;
  } fifo_res_t;

  typedef struct {
    bit                             cfg_en;
    logic [brf_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [brf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic [2:0]                     act;
    logic [7:0]                     din;
    logic [brf_pkg::STEP_W-1:0]     step;
    bit                             typed;
    fifo_res_t                      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  brf_in_if  action_ch ();
  brf_out_if result_ch ();
  brf_cfg_if cfg_ch ();

  byte_ring_fifo_overwrite_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (action_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // FIFO model state
  logic [7:0]  ring_mem [brf_pkg::DEPTH];
  int unsigned rd_ptr, wr_ptr, held, cap_now;
  bit          ovw_now;

  fifo_res_t pending_results [$];
  int        mismatches = 0;
  bit        cur_typed = 1'b0;
  fifo_res_t cur_res = '0;
  bit        no_gaps = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  int        cycles = 0;

  function automatic int unsigned ring_add(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    if (s >= cap_now) s -= cap_now;
    return s;
  endfunction

  function automatic void ring_empty();
    rd_ptr = 0;
    wr_ptr = 0;
    held   = 0;
  endfunction

  function automatic void ring_config(logic [brf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [brf_pkg::CFG_DATA_W-1:0] d);
    int unsigned v;
    v = 32'(d);
    if (idx == brf_pkg::REG_CAPACITY) begin
      if (v < brf_pkg::CAP_MIN_INT) v = brf_pkg::CAP_MIN_INT;
      if (v > brf_pkg::DEPTH) v = brf_pkg::DEPTH;
      cap_now = v;
      ring_empty();
    end else if (idx == brf_pkg::REG_OVERWRITE) begin
      ovw_now = d[0];
    end
  endfunction

  function automatic fifo_res_t ring_apply(logic [2:0] act, logic [7:0] din,
                                           logic [brf_pkg::STEP_W-1:0] step);
    fifo_res_t   r;
    int unsigned n;
    int unsigned run;
    bit          ok;
    r = '0;
    r.status = brf_pkg::ST_OK;
    n = 32'(step);
    case (act)
      brf_pkg::ACT_PUT: begin
        ok = 1'b1;
        if (held >= cap_now) begin
          if (ovw_now) begin
            rd_ptr = ring_add(rd_ptr, 1);
            held--;
            r.status = brf_pkg::ST_OVERWRITE;
          end else begin
            r.status = brf_pkg::ST_FULL;
            ok = 1'b0;
          end
        end
        if (ok) begin
          ring_mem[wr_ptr] = din;
          wr_ptr = ring_add(wr_ptr, 1);
          held++;
        end
      end
      brf_pkg::ACT_GET: begin
        if (held == 0) begin
          r.status = brf_pkg::ST_EMPTY;
        end else begin
          r.read_byte = ring_mem[rd_ptr];
          rd_ptr = ring_add(rd_ptr, 1);
          held--;
          if (held == 0) ring_empty();
        end
      end
      brf_pkg::ACT_SKIP: begin
        if (!ovw_now) begin
          held -= (n < held) ? n : held;
          if (held != 0) rd_ptr = ring_add(rd_ptr, n);
          else ring_empty();
        end
      end
      brf_pkg::ACT_COMMIT: begin
        if (!ovw_now) begin
          if (n > cap_now - held) begin
            r.status = brf_pkg::ST_STEP;
          end else begin
            held += n;
            wr_ptr = ring_add(wr_ptr, n);
          end
        end
      end
      brf_pkg::ACT_CLEAR: ring_empty();
      default: ;
    endcase
    if (held == 0) run = 0;
    else if (rd_ptr < wr_ptr) run = held;
    else run = cap_now - rd_ptr;
    r.fill_level     = brf_pkg::CNT_W'(held);
    r.free_space     = brf_pkg::CNT_W'(cap_now - held);
    r.contiguous_run = brf_pkg::CNT_W'(run);
    r.read_position  = brf_pkg::ADDR_W'(rd_ptr);
    r.write_position = brf_pkg::ADDR_W'(wr_ptr);
    return r;
  endfunction

  function automatic fifo_res_t mk_res(logic [7:0] rb, logic [2:0] st, int unsigned fill,
                                       int unsigned free, int unsigned run,
                                       int unsigned rp, int unsigned wp);
    fifo_res_t r;
    r.read_byte      = rb;
    r.status         = st;
    r.fill_level     = brf_pkg::CNT_W'(fill);
    r.free_space     = brf_pkg::CNT_W'(free);
    r.contiguous_run = brf_pkg::CNT_W'(run);
    r.read_position  = brf_pkg::ADDR_W'(rp);
    r.write_position = brf_pkg::ADDR_W'(wp);
    return r;
  endfunction

  function automatic dir_row_t mk_row(bit cfg_en, logic [brf_pkg::CFG_IDX_W-1:0] cfg_idx,
                                      logic [brf_pkg::CFG_DATA_W-1:0] cfg_data,
                                      logic [2:0] act, logic [7:0] din,
                                      logic [brf_pkg::STEP_W-1:0] step,
                                      bit typed, fifo_res_t res);
    dir_row_t row;
    row.cfg_en   = cfg_en;
    row.cfg_idx  = cfg_idx;
    row.cfg_data = cfg_data;
    row.act      = act;
    row.din      = din;
    row.step     = step;
    row.typed    = typed;
    row.res      = res;
    return row;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic cmp_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_action(input logic [2:0] act, input logic [7:0] din,
                             input logic [brf_pkg::STEP_W-1:0] step, input bit typed,
                             input fifo_res_t res, input int gap);
    if (gap > 0) begin
      action_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action_ch.valid      <= 1'b1;
    action_ch.action     <= act;
    action_ch.data_byte  <= din;
    action_ch.step_count <= step;
    cur_typed            <= typed;
    cur_res              <= res;
    do @(posedge clk); while (!action_ch.ready);
  endtask

  task automatic write_reg(input logic [brf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brf_pkg::CFG_DATA_W-1:0] d);
    action_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // model update on every transfer, then result check
  always @(posedge clk) begin
    fifo_res_t pred;
    fifo_res_t got;
    fifo_res_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) ring_config(cfg_ch.index, cfg_ch.data);
      if (action_ch.valid && action_ch.ready) begin
        pred = ring_apply(action_ch.action, action_ch.data_byte, action_ch.step_count);
        pending_results.push_back(cur_typed ? cur_res : pred);
      end
      if (result_ch.valid && result_ch.ready) begin
        got.read_byte      = result_ch.read_byte;
        got.status         = result_ch.status;
        got.fill_level     = result_ch.fill_level;
        got.free_space     = result_ch.free_space;
        got.contiguous_run = result_ch.contiguous_run;
        got.read_position  = result_ch.read_position;
        got.write_position = result_ch.write_position;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          cmp_field("read_byte", 11'(want.read_byte), 11'(got.read_byte));
          cmp_field("status", 11'(want.status), 11'(got.status));
          cmp_field("fill_level", want.fill_level, got.fill_level);
          cmp_field("free_space", want.free_space, got.free_space);
          cmp_field("contiguous_run", want.contiguous_run, got.contiguous_run);
          cmp_field("read_position", 11'(want.read_position), 11'(got.read_position));
          cmp_field("write_position", 11'(want.write_position), 11'(got.write_position));
        end
      end
    end
  end

  // result sink: random stalls, one long hold-off
  initial begin
    int n;
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        n = no_gaps ? 0 : gap_len();
        if (n > 0) begin
          result_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t    dir_rows [$];
    dir_row_t    row;
    fifo_res_t   idle_res;
    logic [2:0]  act;
    logic [10:0] cap_raw;
    int unsigned cap_eff;
    int          put_w;
    int          r;
    int          gap;
    logic [brf_pkg::STEP_W-1:0] step;

    for (int i = 0; i < brf_pkg::DEPTH; i++) ring_mem[i] = 8'h00;
    ring_empty();
    cap_now = brf_pkg::CAP_RESET_INT;
    ovw_now = 1'b0;

    action_ch.valid      <= 1'b0;
    action_ch.action     <= brf_pkg::ACT_STATUS;
    action_ch.data_byte  <= 8'h00;
    action_ch.step_count <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= brf_pkg::REG_CAPACITY;
    cfg_ch.data          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    idle_res = mk_res(8'h00, brf_pkg::ST_OK, 0, 1024, 0, 0, 0);
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_STATUS, 8'h00, 0, 1,
                              idle_res));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_GET, 8'h00, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_EMPTY, 0, 1024, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_PUT, 8'hFF, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 1, 1023, 1, 0, 1)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_PUT, 8'h00, 2047, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 2, 1022, 2, 0, 2)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_GET, 8'h00, 0, 1,
                              mk_res(8'hFF, brf_pkg::ST_OK, 1, 1023, 1, 1, 2)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_GET, 8'hFF, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 0, 1024, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 1025, 1,
                              mk_res(8'h00, brf_pkg::ST_STEP, 0, 1024, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 2047, 1,
                              mk_res(8'h00, brf_pkg::ST_STEP, 0, 1024, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 1024, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 1024, 0, 1024, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_PUT, 8'hA5, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_FULL, 1024, 0, 1024, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_SKIP, 8'h00, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 1024, 0, 1024, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_SKIP, 8'h00, 2047, 1,
                              idle_res));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_PUT, 8'h5A, 0, 0,
                              '0));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_CLEAR, 8'h00, 0, 1,
                              idle_res));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, ACT_ALIAS6, 8'hFF, 2047, 1,
                              idle_res));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, ACT_ALIAS7, 8'h00, 0, 1,
                              idle_res));
    // capacity below range clamps to the minimum
    dir_rows.push_back(mk_row(1, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 33, 1,
                              mk_res(8'h00, brf_pkg::ST_STEP, 0, 32, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 32, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 32, 0, 32, 0, 0)));
    dir_rows.push_back(mk_row(1, brf_pkg::REG_OVERWRITE, 1, brf_pkg::ACT_PUT, 8'h3C, 0, 1,
                              mk_res(8'h00, brf_pkg::ST_OVERWRITE, 32, 0, 31, 1, 1)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_SKIP, 8'h00, 5, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 32, 0, 31, 1, 1)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_COMMIT, 8'h00, 5, 1,
                              mk_res(8'h00, brf_pkg::ST_OK, 32, 0, 31, 1, 1)));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_GET, 8'h00, 0, 0,
                              '0));
    dir_rows.push_back(mk_row(0, brf_pkg::REG_CAPACITY, 0, brf_pkg::ACT_PUT, 8'hC3, 0, 0,
                              '0));
    // capacity above range clamps to DEPTH
    dir_rows.push_back(mk_row(1, brf_pkg::REG_CAPACITY, 2047, brf_pkg::ACT_STATUS, 8'h00, 0, 1,
                              idle_res));
    dir_rows.push_back(mk_row(1, REG_SPARE2, 2047, brf_pkg::ACT_STATUS, 8'h00, 0, 1,
                              idle_res));
    dir_rows.push_back(mk_row(1, REG_SPARE3, 0, brf_pkg::ACT_STATUS, 8'h00, 0, 1,
                              idle_res));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg_en) write_reg(row.cfg_idx, row.cfg_data);
      send_action(row.act, row.din, row.step, row.typed, row.res, gap_len());
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: cap_raw = 11'd32;
        1: cap_raw = 11'd1024;
        2: cap_raw = 11'd2047;
        3: cap_raw = 11'd0;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) cap_raw = 11'd1024;
          else if (r == 1) cap_raw = 11'($urandom_range(0, 2047));
          else cap_raw = 11'($urandom_range(32, 64));
        end
      endcase
      cap_eff = 32'(cap_raw);
      if (cap_eff < brf_pkg::CAP_MIN_INT) cap_eff = brf_pkg::CAP_MIN_INT;
      if (cap_eff > brf_pkg::DEPTH) cap_eff = brf_pkg::DEPTH;
      write_reg(brf_pkg::REG_CAPACITY, cap_raw);
      write_reg(brf_pkg::REG_OVERWRITE,
                (ph < 4) ? brf_pkg::CFG_DATA_W'(ph % 2 == 0) :
                           brf_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: put_w = 30;
        1: put_w = 45;
        default: put_w = 60;
      endcase
      no_gaps = (ph % 5 == 2);
      if (ph == 3) hold_req = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < put_w) begin
          act = brf_pkg::ACT_PUT;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) act = brf_pkg::ACT_GET;
          else if (r < 62) act = brf_pkg::ACT_SKIP;
          else if (r < 76) act = brf_pkg::ACT_COMMIT;
          else if (r < 80) act = brf_pkg::ACT_CLEAR;
          else if (r < 92) act = brf_pkg::ACT_STATUS;
          else act = $urandom_range(0, 1) ? ACT_ALIAS6 : ACT_ALIAS7;
        end
        case ($urandom_range(0, 9))
          0: step = '0;
          1: step = brf_pkg::STEP_W'(1);
          2, 3, 4: step = brf_pkg::STEP_W'($urandom_range(0, 8));
          5, 6: step = brf_pkg::STEP_W'($urandom_range(0, cap_eff));
          7: step = brf_pkg::STEP_W'(cap_eff);
          8: step = brf_pkg::STEP_W'($urandom_range(0, 2047));
          default: step = brf_pkg::STEP_W'($urandom_range(cap_eff, 2047));
        endcase
        gap = (no_gaps || (hold_req && !hold_done)) ? 0 : gap_len();
        send_action(act, 8'($urandom_range(0, 255)), step, 1'b0, '0, gap);
      end
    end

    action_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* byte_ring_fifo_overwrite_core.f */
+incdir+rtl
rtl/brf_pkg.sv
rtl/brf_channels.sv
rtl/brf_ram.sv
rtl/brf_ctrl.sv
rtl/byte_ring_fifo_overwrite_core.sv
test/tb_byte_ring_fifo_overwrite_core.sv
